### design/ffba_pkg.sv
// Package: sizes, codes, item structs and sequencer states of the block allocator.
`default_nettype none
package ffba_pkg;

	localparam int BLOCK_COUNT = 8;
	localparam int BLOCK_BYTES = 128;
	localparam int STORE_BYTES = BLOCK_COUNT * BLOCK_BYTES;

	localparam int BLK_W  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int CUR_W  = $clog2(BLOCK_BYTES + 1);
	localparam int SUM_W  = $clog2(STORE_BYTES + 1);
	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int FLD_W  = 11;
	localparam int CMP_W  = (SUM_W > FLD_W) ? SUM_W : FLD_W;

	localparam logic [2:0] MODE_ALLOC = 3'd0;
	localparam logic [2:0] MODE_FREE  = 3'd1;
	localparam logic [2:0] MODE_READ  = 3'd2;
	localparam logic [2:0] MODE_WRITE = 3'd3;
	localparam logic [2:0] MODE_MERGE = 3'd4;

	typedef struct packed {
		logic [2:0]       mode;
		logic [3:0]       handle;
		logic [FLD_W-1:0] request_size;
		logic [7:0]       write_byte;
	} req_t;

	typedef struct packed {
		logic             status;
		logic [3:0]       granted_handle;
		logic [7:0]       read_byte;
		logic [FLD_W-1:0] free_bytes;
		logic [FLD_W-1:0] largest_free;
		logic [FLD_W-1:0] smallest_free;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIT,
		S_FREE,
		S_SEEK,
		S_RDWAIT,
		S_MERGE,
		S_STATS,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

### design/first_fit_block_allocator.sv
// Top level: first-fit block allocator with block table sequencer and byte store.
//
//  channel | valid     | stall     | payload        | direction
//  --------+-----------+-----------+----------------+----------
//  request | req_valid | req_stall | req (req_t)    | into block
//  result  | rsp_valid | rsp_stall | rsp (rsp_t)    | out of block
//
// One item is taken at a time. The sequencer walks the block table one block per
// cycle: an operation pass (alloc, free, seek, coalesce; none when the item
// already fails its check on acceptance), a byte store read for a read, and a
// statistics pass over every block, between the step that accepts the item and
// the step that loads the result.
// Reset sets the block table to one free run over all blocks at once; the byte
// store is not cleared and needs no clearing pass.
// A result held in the output register under stall does not block the next
// item; only a second finished result waits for the register to drain.
`default_nettype none
module first_fit_block_allocator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ffba_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ffba_pkg::rsp_t     rsp
);

	import ffba_pkg::*;

	// sequencer and block table
	state_t                 state_q, state_d;
	logic [BLOCK_COUNT-1:0] used_q, used_d;
	logic [BLOCK_COUNT-1:0] chained_q, chained_d;
	logic [BLOCK_COUNT-1:0] run_start_q, run_start_d;
	logic [CUR_W-1:0]       cursor_q [BLOCK_COUNT];
	logic [CUR_W-1:0]       cursor_d [BLOCK_COUNT];
	logic                   rsp_valid_q, rsp_valid_d;

	// walker and working registers
	req_t              req_q, req_d;
	logic [BLK_W-1:0]  p_q, p_d;
	logic [BLK_W-1:0]  st_q, st_d;
	logic              in_run_q, in_run_d;
	logic              prev_free_q, prev_free_d;
	logic [SUM_W-1:0]  run_bytes_q, run_bytes_d;
	logic [SUM_W-1:0]  free_acc_q, free_acc_d;
	logic [SUM_W-1:0]  largest_q, largest_d;
	logic [SUM_W-1:0]  smallest_q, smallest_d;
	logic              status_q, status_d;
	logic [3:0]        granted_q, granted_d;
	logic [7:0]        rbyte_q, rbyte_d;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_load;

	// byte store port
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_rdata;

	// shared walk step over block p_q
	logic              used_p, chained_p, at_last;
	logic              starts, member, continues, fits;
	logic [CUR_W-1:0]  cur_p;
	logic [BLK_W-1:0]  p_inc, p_m1, st_sel, hb;
	logic [SUM_W-1:0]  run_bytes_nx;
	logic              hv;

	assign used_p       = used_q[p_q];
	assign chained_p    = chained_q[p_q];
	assign cur_p        = cursor_q[p_q];
	assign at_last      = (p_q == BLK_W'(BLOCK_COUNT - 1));
	assign p_inc        = p_q + BLK_W'(1);
	assign p_m1         = p_q - BLK_W'(1);
	assign starts       = !in_run_q && !used_p;
	assign member       = in_run_q || !used_p;
	assign continues    = member && !at_last && chained_p;
	assign run_bytes_nx = (in_run_q ? run_bytes_q : '0) + SUM_W'(BLOCK_BYTES);
	assign fits         = member && (CMP_W'(run_bytes_nx) >= CMP_W'(req_q.request_size));
	assign st_sel       = starts ? p_q : st_q;

	// handle check on the incoming item
	assign hv = (req.handle != '0) && (int'(req.handle) <= BLOCK_COUNT);
	assign hb = BLK_W'(int'(req.handle) - 1);

	ffba_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(req_q.write_byte),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			chained_q   <= {1'b0, {(BLOCK_COUNT-1){1'b1}}};
			run_start_q <= BLOCK_COUNT'(1);
			cursor_q    <= '{default: '0};
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			used_q      <= used_d;
			chained_q   <= chained_d;
			run_start_q <= run_start_d;
			cursor_q    <= cursor_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// payload and walker registers: every path sets them before use
	always_ff @(posedge clk) begin
		req_q       <= req_d;
		p_q         <= p_d;
		st_q        <= st_d;
		in_run_q    <= in_run_d;
		prev_free_q <= prev_free_d;
		run_bytes_q <= run_bytes_d;
		free_acc_q  <= free_acc_d;
		largest_q   <= largest_d;
		smallest_q  <= smallest_d;
		status_q    <= status_d;
		granted_q   <= granted_d;
		rbyte_q     <= rbyte_d;
		rsp_q       <= rsp_d;
	end

	always_comb begin
		state_d     = state_q;
		used_d      = used_q;
		chained_d   = chained_q;
		run_start_d = run_start_q;
		cursor_d    = cursor_q;
		req_d       = req_q;
		p_d         = p_q;
		st_d        = st_q;
		in_run_d    = in_run_q;
		prev_free_d = prev_free_q;
		run_bytes_d = run_bytes_q;
		free_acc_d  = free_acc_q;
		largest_d   = largest_q;
		smallest_d  = smallest_q;
		status_d    = status_q;
		granted_d   = granted_q;
		rbyte_d     = rbyte_q;
		rsp_load    = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_addr    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					// latch the item, assume failure until an operation succeeds
					req_d       = req;
					status_d    = 1'b1;
					granted_d   = '0;
					rbyte_d     = '0;
					p_d         = '0;
					in_run_d    = 1'b0;
					prev_free_d = 1'b0;
					state_d     = S_STATS;
					unique case (req.mode) inside
						MODE_ALLOC: begin
							if (req.request_size != '0) begin
								state_d = S_FIT;
							end
						end
						MODE_FREE: begin
							if (hv && run_start_q[hb]) begin
								p_d     = hb;
								state_d = S_FREE;
							end
						end
						MODE_READ, MODE_WRITE: begin
							if (hv) begin
								p_d     = hb;
								state_d = S_SEEK;
							end
						end
						MODE_MERGE: begin
							status_d = 1'b0;
							state_d  = S_MERGE;
						end
						default: begin
							state_d = S_STATS;
						end
					endcase
				end
			end
			S_FIT: begin
				if (fits) begin
					// the block that reaches the size ends the allocation
					for (int j = 0; j < BLOCK_COUNT; j++) begin
						if (BLK_W'(j) >= st_sel && BLK_W'(j) <= p_q) begin
							used_d[j]   = 1'b1;
							cursor_d[j] = '0;
						end
					end
					run_start_d[st_sel] = 1'b1;
					if (chained_p) begin
						chained_d[p_q] = 1'b0;
						if (!at_last) begin
							run_start_d[p_inc] = 1'b1;
						end
					end
					status_d  = 1'b0;
					granted_d = 4'(int'(st_sel) + 1);
					state_d   = S_STATS;
				end else if (continues) begin
					if (starts) begin
						st_d = p_q;
					end
					run_bytes_d = run_bytes_nx;
					in_run_d    = 1'b1;
					p_d         = p_inc;
				end else if (at_last) begin
					state_d = S_STATS;
				end else begin
					in_run_d = 1'b0;
					p_d      = p_inc;
				end
			end
			S_FREE: begin
				used_d[p_q]   = 1'b0;
				cursor_d[p_q] = '0;
				if (!at_last && chained_p) begin
					p_d = p_inc;
				end else begin
					status_d = 1'b0;
					state_d  = S_STATS;
				end
			end
			S_SEEK: begin
				if (cur_p >= CUR_W'(BLOCK_BYTES) && !at_last && chained_p) begin
					p_d = p_inc;
				end else if (req_q.mode == MODE_READ) begin
					state_d = S_STATS;
					if (cur_p != '0) begin
						cursor_d[p_q] = cur_p - CUR_W'(1);
						ram_re        = 1'b1;
						ram_addr      = ADDR_W'(int'(p_q) * BLOCK_BYTES + int'(cur_p) - 1);
						status_d      = 1'b0;
						state_d       = S_RDWAIT;
					end
				end else begin
					if (cur_p < CUR_W'(BLOCK_BYTES)) begin
						cursor_d[p_q] = cur_p + CUR_W'(1);
						ram_we        = 1'b1;
						ram_addr      = ADDR_W'(int'(p_q) * BLOCK_BYTES + int'(cur_p));
						status_d      = 1'b0;
					end
					state_d = S_STATS;
				end
			end
			S_RDWAIT: begin
				rbyte_d = ram_rdata;
				state_d = S_STATS;
			end
			S_MERGE: begin
				// a free block after a free block extends the link behind it
				if (!used_p && !prev_free_q) begin
					run_start_d[p_q] = 1'b1;
				end
				if (!used_p && prev_free_q) begin
					chained_d[p_m1] = 1'b1;
				end
				prev_free_d = !used_p;
				if (at_last) begin
					state_d = S_STATS;
				end else begin
					p_d = p_inc;
				end
			end
			S_STATS: begin
				if (!used_p) begin
					free_acc_d = free_acc_q + SUM_W'(BLOCK_BYTES);
				end
				if (member && !continues) begin
					if (run_bytes_nx > largest_q) begin
						largest_d = run_bytes_nx;
					end
					if (run_bytes_nx < smallest_q) begin
						smallest_d = run_bytes_nx;
					end
				end
				if (continues) begin
					in_run_d    = 1'b1;
					run_bytes_d = run_bytes_nx;
				end else begin
					in_run_d = 1'b0;
				end
				if (at_last) begin
					state_d = S_DONE;
				end else begin
					p_d = p_inc;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// start the statistics pass from the first block
		if (state_d == S_STATS && state_q != S_STATS) begin
			p_d        = '0;
			in_run_d   = 1'b0;
			free_acc_d = '0;
			largest_d  = '0;
			smallest_d = SUM_W'(STORE_BYTES);
		end
	end

	always_comb begin
		rsp_d = rsp_q;
		if (rsp_load) begin
			rsp_d.status         = status_q;
			rsp_d.granted_handle = granted_q;
			rsp_d.read_byte      = rbyte_q;
			rsp_d.free_bytes     = FLD_W'(free_acc_q);
			rsp_d.largest_free   = FLD_W'(largest_q);
			rsp_d.smallest_free  = FLD_W'(smallest_q);
		end
		rsp_valid_d = rsp_valid_q;
		if (rsp_load) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_DONE))
		else $error("result appeared outside the result load step");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && rsp_stall) |=> state_q == S_DONE)
		else $error("finished result dropped while output register was full");

	a_last_unlinked: assert property (@(posedge clk) disable iff (!arst_n)
		!chained_q[BLOCK_COUNT-1])
		else $error("last block linked past the end of the store");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> cursor_q[p_q] <= CUR_W'(BLOCK_BYTES))
		else $error("block cursor beyond block size");
`endif

endmodule
`default_nettype wire

### design/ffba_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire
